FILE: rtl/ssch_pkg.sv
// ----------------------------------------------------------------------------
// ssch_pkg
// Shared widths, status codes and sequencer states of the spike check and
// heal block.
// ----------------------------------------------------------------------------
package ssch_pkg;

	localparam int SAMPLE_W = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UNSTABLE    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_TRIPLE_JUMP = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_UNRETURNED  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_TAIL_UNRET  = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW    = 3'd5;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_TAIL,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/ssch_store.sv
// ----------------------------------------------------------------------------
// ssch_store
// Trace sample memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssch_store
	import ssch_pkg::*;
#(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic signed [SAMPLE_W-1:0] wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic signed [SAMPLE_W-1:0] rdata
);

	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/sample_spike_check_and_heal.sv
// ----------------------------------------------------------------------------
// sample_spike_check_and_heal
// Loads a trace of signed samples, checks neighbour steps against
// max_difference, heals single spikes and emits the trace with its status.
//
// Input channel (in_valid / in_ready): one sample per beat, last marks the
// end of the trace. Samples are written to the trace memory, one per cycle.
// Samples beyond MAX_SAMPLES are dropped and the trace reports overflow.
// After the last beat the sequencer reads the memory once in order, keeps a
// four-sample window, writes healed samples back and resolves the tail; a scan
// error skips the tail, and traces that overflow or hold three samples or fewer
// skip both. Output channel (out_valid / out_ready): the stored samples, one per
// beat through a read stage and an output register; the final beat carries
// end_of_trace, status and repair_count. The scan and the emit share the single
// read port of the trace memory.
// in_ready is low while the trace is scanned or emitted; the next trace is
// taken once every read is issued and the read stage is empty. A stalled
// receiver holds the output register and stops further reads.
// Reset clears the sequencer, counters and output valid; max_difference
// returns to 120. The memory is not cleared.
// ----------------------------------------------------------------------------
module sample_spike_check_and_heal
	import ssch_pkg::*;
#(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [15:0]                cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] healed_sample,
	output logic                       end_of_trace,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         repair_count
);

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] START_POS = CNT_W'(2);
	localparam logic [CNT_W-1:0] SCAN_POS  = CNT_W'(5);
	localparam logic [CNT_W-1:0] SHORT_MAX = CNT_W'(3);

	function automatic logic is_jump(input logic signed [SAMPLE_W-1:0] a,
	                                 input logic signed [SAMPLE_W-1:0] b,
	                                 input logic [15:0] limit);
		logic signed [SAMPLE_W:0] d;
		logic [SAMPLE_W:0]        mag;
		d   = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
		mag = d[SAMPLE_W] ? unsigned'(-d) : unsigned'(d);
		return mag > {1'b0, limit};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] average(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b);
		logic signed [SAMPLE_W:0] s;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		s = s + {{SAMPLE_W{1'b0}}, s[SAMPLE_W]};
		return s[SAMPLE_W:1];
	endfunction

	state_t                     state_q, state_d;
	logic [15:0]                max_diff_q;
	logic [CNT_W-1:0]           fill_q, n_q, rk_q, ek_q, arr_k_s1;
	logic                       ovf_q, arr_v_s1, stop_q;
	logic [1:0]                 skip_q;
	logic [STATUS_W-1:0]        status_q;
	logic [COUNT_W-1:0]         tally_q;
	logic signed [SAMPLE_W-1:0] w1_q, w2_q, w3_q;
	logic                       f12_q, f23_q;

	logic                       em_v_s1, em_last_s1;
	logic [STATUS_W-1:0]        em_status_s1;
	logic [COUNT_W-1:0]         em_count_s1;

	logic                       out_valid_q, out_last_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic [STATUS_W-1:0]        out_status_q;
	logic [COUNT_W-1:0]         out_count_q;

	logic                       mem_we, mem_re;
	logic [ADDR_W-1:0]          mem_wa, mem_ra;
	logic signed [SAMPLE_W-1:0] mem_wd, mem_rd;

	logic                       in_fire, room;
	logic [CNT_W-1:0]           fill_next;
	logic                       ovf_next;
	logic                       fnew;
	logic signed [SAMPLE_W-1:0] avg_w13;
	logic                       decide, err_start, err_ret, err_trip, heal_now;
	logic                       scan_issue, scan_done;
	logic                       tail_ja, tail_fix;
	logic                       move, emit_issue;

	ssch_store #(
		.DEPTH  (MAX_SAMPLES),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (mem_ra),
		.rdata (mem_rd)
	);

	// load side
	assign in_ready  = (state_q == ST_LOAD) && !em_v_s1;
	assign in_fire   = in_valid && in_ready;
	assign room      = fill_q < MAX_CNT;
	assign fill_next = room ? fill_q + CNT_W'(1) : fill_q;
	assign ovf_next  = ovf_q || !room;

	// scan window decisions
	assign fnew      = is_jump(w3_q, mem_rd, max_diff_q);
	assign avg_w13   = average(w1_q, w3_q);
	assign decide    = arr_v_s1 && (arr_k_s1 >= SCAN_POS) && !stop_q && (skip_q == 2'd0);
	assign err_start = arr_v_s1 && (arr_k_s1 == START_POS) && !stop_q && (f23_q || fnew);
	assign err_ret   = decide && f12_q && !f23_q;
	assign err_trip  = decide && f12_q && f23_q && fnew;
	assign heal_now  = decide && f12_q && f23_q && !fnew;
	assign scan_issue = (state_q == ST_SCAN) && (rk_q < n_q);
	assign scan_done  = arr_v_s1 && (arr_k_s1 == n_q - CNT_W'(1));

	// tail
	assign tail_ja  = is_jump(w1_q, w2_q, max_diff_q);
	assign tail_fix = f23_q;

	// emit side
	assign move       = em_v_s1 && (!out_valid_q || out_ready);
	assign emit_issue = (state_q == ST_EMIT) && (ek_q < n_q) && (!em_v_s1 || move);

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = fill_q[ADDR_W-1:0];
		mem_wd  = sample;
		mem_re  = 1'b0;
		mem_ra  = rk_q[ADDR_W-1:0];
		case (state_q)
			ST_LOAD: begin
				mem_we = in_fire && room;
				if (in_fire && last) begin
					if (ovf_next || fill_next <= SHORT_MAX) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				mem_re = scan_issue;
				mem_we = heal_now;
				mem_wa = ADDR_W'(arr_k_s1 - CNT_W'(2));
				mem_wd = avg_w13;
				if (scan_done) begin
					if (stop_q || err_start || err_ret || err_trip) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				mem_we  = tail_fix;
				mem_wa  = tail_ja ? ADDR_W'(n_q - CNT_W'(2)) : ADDR_W'(n_q - CNT_W'(1));
				mem_wd  = tail_ja ? avg_w13 : w2_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				mem_re = emit_issue;
				mem_ra = ek_q[ADDR_W-1:0];
				if (emit_issue && (ek_q == n_q - CNT_W'(1))) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_diff_q <= 16'd120;
		end else if (cfg_we) begin
			max_diff_q <= cfg_wdata;
		end
	end

	// trace control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			n_q      <= '0;
			rk_q     <= '0;
			ek_q     <= '0;
			arr_v_s1 <= 1'b0;
			arr_k_s1 <= '0;
			stop_q   <= 1'b0;
			skip_q   <= 2'd0;
			status_q <= STAT_OK;
			tally_q  <= '0;
		end else begin
			arr_v_s1 <= scan_issue;
			if (scan_issue) begin
				arr_k_s1 <= rk_q;
				rk_q     <= rk_q + CNT_W'(1);
			end
			if (in_fire) begin
				if (last) begin
					fill_q   <= '0;
					ovf_q    <= 1'b0;
					n_q      <= fill_next;
					rk_q     <= '0;
					ek_q     <= '0;
					stop_q   <= 1'b0;
					skip_q   <= 2'd0;
					tally_q  <= '0;
					status_q <= ovf_next ? STAT_OVERFLOW : STAT_OK;
				end else begin
					fill_q <= fill_next;
					ovf_q  <= ovf_next;
				end
			end
			if (state_q == ST_SCAN && arr_v_s1) begin
				if (skip_q != 2'd0 && arr_k_s1 >= SCAN_POS) begin
					skip_q <= skip_q - 2'd1;
				end
				if (err_start) begin
					stop_q   <= 1'b1;
					status_q <= STAT_UNSTABLE;
				end
				if (err_ret) begin
					stop_q   <= 1'b1;
					status_q <= STAT_UNRETURNED;
				end
				if (err_trip) begin
					stop_q   <= 1'b1;
					status_q <= STAT_TRIPLE_JUMP;
				end
				if (heal_now) begin
					skip_q  <= 2'd2;
					tally_q <= tally_q + COUNT_W'(1);
				end
			end
			if (state_q == ST_TAIL) begin
				if (tail_fix) begin
					tally_q <= tally_q + COUNT_W'(1);
				end else if (tail_ja) begin
					status_q <= STAT_TAIL_UNRET;
				end
			end
			if (emit_issue) begin
				ek_q <= ek_q + CNT_W'(1);
			end
		end
	end

	// sample window, shifted on each scan read beat
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && arr_v_s1) begin
			w1_q  <= heal_now ? avg_w13 : w2_q;
			w2_q  <= w3_q;
			w3_q  <= mem_rd;
			f12_q <= f23_q;
			f23_q <= fnew;
		end
	end

	// read stage of the emit path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_s1 <= 1'b0;
		end else if (emit_issue) begin
			em_v_s1 <= 1'b1;
		end else if (move) begin
			em_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_issue) begin
			em_last_s1   <= (ek_q == n_q - CNT_W'(1));
			em_status_s1 <= status_q;
			em_count_s1  <= tally_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_sample_q <= mem_rd;
			out_last_q   <= em_last_s1;
			out_status_q <= em_last_s1 ? em_status_s1 : STAT_OK;
			out_count_q  <= em_last_s1 ? em_count_s1 : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign healed_sample = out_sample_q;
	assign end_of_trace  = out_last_q;
	assign status        = out_status_q;
	assign repair_count  = out_count_q;

endmodule
